FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");

`endif

FILE: sv/scl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_pkg
// Types, character codes and keywords of the command line recognizer.
// ----------------------------------------------------------------------------
package scl_pkg;

   localparam int HEAD_DEPTH = 5;
   localparam int HEAD_IDX_W = 3;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;

   localparam logic [31:0] KW_HELP = "help";
   localparam logic [23:0] KW_LOF  = "lof";
   localparam logic [23:0] KW_LON  = "lon";
   localparam logic [31:0] KW_TEST = "test";

   localparam logic [1:0] ECHO_NONE    = 2'd0;
   localparam logic [1:0] ECHO_BYTE    = 2'd1;
   localparam logic [1:0] ECHO_ERASE   = 2'd2;
   localparam logic [1:0] ECHO_NEWLINE = 2'd3;

   localparam logic [1:0] VERDICT_EMPTY   = 2'd0;
   localparam logic [1:0] VERDICT_KNOWN   = 2'd1;
   localparam logic [1:0] VERDICT_UNKNOWN = 2'd2;

   localparam logic [1:0] CMD_HELP = 2'd0;
   localparam logic [1:0] CMD_LOF  = 2'd1;
   localparam logic [1:0] CMD_LON  = 2'd2;
   localparam logic [1:0] CMD_TEST = 2'd3;

   typedef logic [HEAD_DEPTH-1:0][7:0] head_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] index;
   } match_type;

   typedef struct packed {
      logic [1:0] echo_kind;
      logic [7:0] echo_byte;
      logic       line_done;
      logic [1:0] verdict;
      logic [1:0] command_index;
   } result_type;

   // first four head characters equal a four-letter keyword
   function automatic logic head_eq4(head_type head, logic [31:0] kw);
      logic eq;
      eq = 1'b1;
      for (int i = 0; i < 4; i++) begin
         eq = eq & (head[i] == kw[8*(3-i) +: 8]);
      end
      return eq;
   endfunction

   // first three head characters equal a three-letter keyword
   function automatic logic head_eq3(head_type head, logic [23:0] kw);
      logic eq;
      eq = 1'b1;
      for (int i = 0; i < 3; i++) begin
         eq = eq & (head[i] == kw[8*(2-i) +: 8]);
      end
      return eq;
   endfunction

endpackage

FILE: sv/serial_command_line_recognizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_line_recognizer_unit
// Line editor and keyword recognizer for received serial bytes.
// ----------------------------------------------------------------------------
// channel | direction | carries
// req_    | in        | one received byte per request
// rsp_    | out       | echo action and line verdict, one per request
//
// One request per cycle sustained while rsp_tready is held; a byte passes the
// input register, then decode and keyword compare into the result register.
// Reset clears the line length and both valid flags.
// A stalled result holds; a new request is still taken while the input
// register can move into the free or draining result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_command_line_recognizer_unit #(
   parameter int LINE_CAPACITY = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] echo_byte, [9:8] verdict, [11:10] command_index
   output logic [1:0]  rsp_tuser,   // [1:0] echo_kind
   output logic        rsp_tlast    // line_done
);
   import scl_pkg::*;

   localparam int LEN_W = $clog2(LINE_CAPACITY);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       out_ready, step;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;

   scl_line_editor #(.LINE_CAPACITY(LINE_CAPACITY), .LEN_W(LEN_W)) u_editor (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_ready) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.command_index, out_ff.verdict, out_ff.echo_byte};
   assign rsp_tuser  = out_ff.echo_kind;
   assign rsp_tlast  = out_ff.line_done;

   `ASSERT_NEXT(a_step_fills_out, clock, reset, step, rsp_tvalid)
   `ASSERT_IMPLIES(a_done_newline, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser == ECHO_NEWLINE)
   `ASSERT_IMPLIES(a_verdict_only_done, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[11:8] == 4'd0)
   `ASSERT_IMPLIES(a_byte_only_echo, clock, reset, rsp_tvalid && rsp_tuser != ECHO_BYTE, rsp_tdata[7:0] == 8'd0)

endmodule

FILE: sv/scl_kw_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_kw_match
// Matches the first token of the stored line head against the keywords.
// ----------------------------------------------------------------------------
module scl_kw_match #(
   parameter int LEN_W = 7
) (
   input  scl_pkg::head_type  head,
   input  logic [LEN_W-1:0]   line_length,
   output scl_pkg::match_type match
);
   import scl_pkg::*;

   logic len_ge3, len_ge4, len_eq3, len_eq4;
   logic end3, end4;
   logic hit_help, hit_lof, hit_lon, hit_test;

   always_comb begin
      len_eq3 = line_length == LEN_W'(3);
      len_eq4 = line_length == LEN_W'(4);
      len_ge3 = line_length >= LEN_W'(3);
      len_ge4 = line_length >= LEN_W'(4);
      // token ends at the line end or at a space
      end3 = len_eq3 || (len_ge4 && head[3] == CHAR_SPACE);
      end4 = len_eq4 || (line_length >= LEN_W'(HEAD_DEPTH) && head[4] == CHAR_SPACE);

      hit_help = len_ge4 && end4 && head_eq4(head, KW_HELP);
      hit_test = len_ge4 && end4 && head_eq4(head, KW_TEST);
      hit_lof  = len_ge3 && end3 && head_eq3(head, KW_LOF);
      hit_lon  = len_ge3 && end3 && head_eq3(head, KW_LON);

      match.hit = hit_help | hit_lof | hit_lon | hit_test;
      if (hit_help) begin
         match.index = CMD_HELP;
      end else if (hit_lof) begin
         match.index = CMD_LOF;
      end else if (hit_lon) begin
         match.index = CMD_LON;
      end else if (hit_test) begin
         match.index = CMD_TEST;
      end else begin
         match.index = CMD_HELP;
      end
   end

endmodule

FILE: sv/scl_line_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_line_editor
// Holds the line length and head characters and decodes one byte per step.
// ----------------------------------------------------------------------------
module scl_line_editor #(
   parameter int LINE_CAPACITY = 128,
   parameter int LEN_W         = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   output scl_pkg::result_type  result
);
   import scl_pkg::*;

   logic [LEN_W-1:0] length_ff, length_in;
   head_type         head_ff;
   logic             head_wr;
   match_type        match;
   logic             is_eol, is_erase, is_print;

   scl_kw_match #(.LEN_W(LEN_W)) u_match (
      .head        (head_ff),
      .line_length (length_ff),
      .match       (match)
   );

   always_comb begin
      is_eol   = rx_byte == CHAR_CR || rx_byte == CHAR_LF;
      is_erase = rx_byte == CHAR_BS || rx_byte == CHAR_DEL;
      is_print = rx_byte >= CHAR_SPACE && rx_byte <= CHAR_TILDE;

      result.echo_kind     = ECHO_NONE;
      result.echo_byte     = 8'd0;
      result.line_done     = 1'b0;
      result.verdict       = VERDICT_EMPTY;
      result.command_index = CMD_HELP;
      length_in            = length_ff;
      head_wr              = 1'b0;

      if (is_eol) begin
         result.echo_kind = ECHO_NEWLINE;
         result.line_done = 1'b1;
         length_in        = '0;
         if (length_ff != '0) begin
            if (match.hit) begin
               result.verdict       = VERDICT_KNOWN;
               result.command_index = match.index;
            end else begin
               result.verdict = VERDICT_UNKNOWN;
            end
         end
      end else if (is_erase) begin
         if (length_ff != '0) begin
            result.echo_kind = ECHO_ERASE;
            length_in        = length_ff - LEN_W'(1);
         end
      end else if (is_print) begin
         if (length_ff < LEN_W'(LINE_CAPACITY - 1)) begin
            result.echo_kind = ECHO_BYTE;
            result.echo_byte = rx_byte;
            length_in        = length_ff + LEN_W'(1);
            head_wr          = length_ff < LEN_W'(HEAD_DEPTH);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (step) begin
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         if (step && head_wr && length_ff[HEAD_IDX_W-1:0] == HEAD_IDX_W'(i)) begin
            head_ff[i] <= rx_byte;
         end
      end
   end

endmodule
